[hw/rtl/kbd_pkg.sv]
// ----------------------------------------------------------------------------
// kbd_pkg
// Types, constants and key/character tables for the set-1 scancode decoder.
// ----------------------------------------------------------------------------
package kbd_pkg;

	localparam int SCAN_W = 8;
	localparam int KEY_W  = 7;
	localparam int MOD_W  = 5;
	localparam int CHAR_W = 7;

	localparam logic [SCAN_W-1:0] PREFIX_BYTE = 8'hE0;

	localparam logic [KEY_W-1:0] SC_LSHIFT = 7'h2A;
	localparam logic [KEY_W-1:0] SC_RSHIFT = 7'h36;
	localparam logic [KEY_W-1:0] SC_CTRL   = 7'h1D;
	localparam logic [KEY_W-1:0] SC_ALT    = 7'h38;
	localparam logic [KEY_W-1:0] SC_OS     = 7'h5B;
	localparam logic [KEY_W-1:0] SC_ANGLE  = 7'h56;
	localparam logic [KEY_W-1:0] SC_SPACE  = 7'h39;

	localparam logic [MOD_W-1:0] M_SHIFT = 5'h01;
	localparam logic [MOD_W-1:0] M_CTRL  = 5'h02;
	localparam logic [MOD_W-1:0] M_ALT   = 5'h04;
	localparam logic [MOD_W-1:0] M_ALTGR = 5'h08;
	localparam logic [MOD_W-1:0] M_OS    = 5'h10;

	typedef struct packed {
		logic             prefix;
		logic [MOD_W-1:0] mods;
	} kbd_state_t;

	function automatic logic key_known(input logic [KEY_W-1:0] sc, input logic ext);
		logic k;
		if (ext)
			k = (sc == SC_ALT);
		else
			k = (sc >= 7'h01 && sc <= 7'h27) || (sc >= 7'h29 && sc <= 7'h36) ||
				sc == SC_ALT || sc == SC_SPACE || sc == SC_ANGLE || sc == SC_OS;
		return k;
	endfunction

	function automatic logic [MOD_W-1:0] key_mod(input logic [KEY_W-1:0] sc,
			input logic ext);
		logic [MOD_W-1:0] m;
		m = '0;
		if (ext)
			m = M_ALTGR;
		else if (sc == SC_ALT)
			m = M_ALT;
		else if (sc == SC_LSHIFT || sc == SC_RSHIFT)
			m = M_SHIFT;
		else if (sc == SC_CTRL)
			m = M_CTRL;
		else if (sc == SC_OS)
			m = M_OS;
		return m;
	endfunction

	function automatic logic [CHAR_W-1:0] letter_of(input logic [KEY_W-1:0] sc);
		logic [CHAR_W-1:0] c;
		case (sc)
			7'h10: c = 7'h71; // q
			7'h11: c = 7'h77; // w
			7'h12: c = 7'h65; // e
			7'h13: c = 7'h72; // r
			7'h14: c = 7'h74; // t
			7'h15: c = 7'h7A; // z
			7'h16: c = 7'h75; // u
			7'h17: c = 7'h69; // i
			7'h18: c = 7'h6F; // o
			7'h19: c = 7'h70; // p
			7'h1E: c = 7'h61; // a
			7'h1F: c = 7'h73; // s
			7'h20: c = 7'h64; // d
			7'h21: c = 7'h66; // f
			7'h22: c = 7'h67; // g
			7'h23: c = 7'h68; // h
			7'h24: c = 7'h6A; // j
			7'h25: c = 7'h6B; // k
			7'h26: c = 7'h6C; // l
			7'h2C: c = 7'h79; // y
			7'h2D: c = 7'h78; // x
			7'h2E: c = 7'h63; // c
			7'h2F: c = 7'h76; // v
			7'h30: c = 7'h62; // b
			7'h31: c = 7'h6E; // n
			7'h32: c = 7'h6D; // m
			default: c = '0;
		endcase
		return c;
	endfunction

	// digit row, keys 0x02..0x0B
	function automatic logic [CHAR_W-1:0] digit_of(input logic [KEY_W-1:0] sc,
			input logic [MOD_W-1:0] m);
		logic [CHAR_W-1:0] p, s, g;
		case (sc)
			7'h02: begin p = 7'h31; s = 7'h21; g = '0; end
			7'h03: begin p = 7'h32; s = 7'h22; g = '0; end
			7'h04: begin p = 7'h33; s = '0;    g = '0; end
			7'h05: begin p = 7'h34; s = 7'h24; g = '0; end
			7'h06: begin p = 7'h35; s = 7'h25; g = '0; end
			7'h07: begin p = 7'h36; s = 7'h26; g = '0; end
			7'h08: begin p = 7'h37; s = 7'h2F; g = 7'h7B; end
			7'h09: begin p = 7'h38; s = 7'h28; g = 7'h5B; end
			7'h0A: begin p = 7'h39; s = 7'h29; g = 7'h5D; end
			7'h0B: begin p = 7'h30; s = 7'h3D; g = 7'h7D; end
			default: begin p = '0; s = '0; g = '0; end
		endcase
		if ((m & M_SHIFT) != '0)
			return s;
		else if ((m & M_ALTGR) != '0)
			return g;
		return p;
	endfunction

	function automatic logic [CHAR_W-1:0] char_of(input logic [KEY_W-1:0] sc,
			input logic ext, input logic [MOD_W-1:0] m);
		logic              pl, sh, ag;
		logic [CHAR_W-1:0] c, l;
		pl = (m == '0);
		sh = (m == M_SHIFT);
		ag = (m == M_ALTGR);
		l  = letter_of(sc);
		c  = '0;
		if (!ext) begin
			case (sc)
				7'h0F: c = 7'h09;
				7'h0E: c = 7'h08;
				7'h1C: c = 7'h0A;
				7'h39: c = 7'h20;
				7'h33: c = sh ? 7'h3B : pl ? 7'h2C : '0;
				7'h34: c = sh ? 7'h3A : pl ? 7'h2E : '0;
				7'h35: c = sh ? 7'h5F : pl ? 7'h2D : '0;
				7'h2B: c = sh ? 7'h27 : pl ? 7'h23 : '0;
				7'h1B: c = sh ? 7'h2A : ag ? 7'h7E : pl ? 7'h2B : '0;
				7'h56: c = sh ? 7'h3E : ag ? 7'h7C : pl ? 7'h3C : '0;
				7'h0C: c = sh ? 7'h3F : ag ? 7'h5C : '0;
				7'h0D: c = sh ? 7'h60 : '0;
				7'h29: c = pl ? 7'h5E : '0;
				default: begin
					if (l != '0) begin
						if ((m & M_ALTGR) != '0 && l == 7'h71)
							c = 7'h40;
						else if ((m & M_SHIFT) != '0)
							c = l - 7'h20;
						else
							c = l;
					end else begin
						c = digit_of(sc, m);
					end
				end
			endcase
		end
		return c;
	endfunction

endpackage

[hw/rtl/keyboard_scancode_to_char_decoder.sv]
// Path: an accepted byte is registered in byte_s1, then in the output registers.
// Throughput: one request per cycle unless out_stall holds the output; the state
// RMW through the one-entry state memory uses a bypass register and adds no wait.
// Reset: clears the pipeline and output valid flags and the memory's valid flag;
// the state entry reads as zero (no prefix, no modifiers) until first written.
// ----------------------------------------------------------------------------
// keyboard_scancode_to_char_decoder
// Set-1 scancode decoder: tracks E0 prefix and modifiers, maps keys to
// German QWERTZ ASCII characters.
// ----------------------------------------------------------------------------
module keyboard_scancode_to_char_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [kbd_pkg::SCAN_W-1:0]  scan_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [kbd_pkg::KEY_W-1:0]   key_code,
	output logic                        extended,
	output logic                        recognized,
	output logic                        released,
	output logic [kbd_pkg::MOD_W-1:0]   modifiers,
	output logic [kbd_pkg::CHAR_W-1:0]  codepoint
);
	import kbd_pkg::*;

	kbd_state_t state_mem [1];
	logic       mem_vld_q;
	kbd_state_t rd_data_s1;
	logic       byp_s1;
	kbd_state_t byp_data_s1;

	logic              v_s1;
	logic [SCAN_W-1:0] byte_s1;

	logic              in_fire, out_free, is_prefix, consume, out_load;
	kbd_state_t        cur_st, new_st;
	logic [KEY_W-1:0]  sc;
	logic              ext, known, rel;
	logic [MOD_W-1:0]  mod, new_mods;

	logic              out_valid_q;
	logic [KEY_W-1:0]  key_code_q;
	logic              extended_q, recognized_q, released_q;
	logic [MOD_W-1:0]  modifiers_q;
	logic [CHAR_W-1:0] codepoint_q;

	assign out_free  = !out_valid_q || !out_stall;
	assign is_prefix = (byte_s1 == PREFIX_BYTE);
	assign consume   = v_s1 && (is_prefix || out_free);
	assign out_load  = v_s1 && !is_prefix && out_free;
	assign in_stall  = v_s1 && !consume;
	assign in_fire   = in_valid && !in_stall;

	assign cur_st = byp_s1 ? byp_data_s1 : rd_data_s1;
	assign sc     = byte_s1[KEY_W-1:0];
	assign rel    = byte_s1[SCAN_W-1];
	assign ext    = cur_st.prefix;

	always_comb begin
		known    = key_known(sc, ext);
		mod      = known ? key_mod(sc, ext) : '0;
		new_mods = rel ? (cur_st.mods & ~mod) : (cur_st.mods | mod);
		if (is_prefix) begin
			new_st.prefix = 1'b1;
			new_st.mods   = cur_st.mods;
		end else begin
			new_st.prefix = 1'b0;
			new_st.mods   = new_mods;
		end
	end

	// state memory: write on consume, read on accept
	always_ff @(posedge clk) begin
		if (consume)
			state_mem[0] <= new_st;
		if (in_fire)
			rd_data_s1 <= mem_vld_q ? state_mem[0] : '0;
		if (in_fire)
			byp_data_s1 <= new_st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_vld_q <= 1'b0;
			v_s1      <= 1'b0;
			byp_s1    <= 1'b0;
		end else begin
			if (consume)
				mem_vld_q <= 1'b1;
			if (in_fire)
				byp_s1 <= consume;
			if (in_fire)
				v_s1 <= 1'b1;
			else if (consume)
				v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire)
			byte_s1 <= scan_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= out_load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			key_code_q   <= sc;
			extended_q   <= ext;
			recognized_q <= known;
			released_q   <= rel;
			modifiers_q  <= new_mods;
			codepoint_q  <= known ? char_of(sc, ext, new_mods) : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign key_code   = key_code_q;
	assign extended   = extended_q;
	assign recognized = recognized_q;
	assign released   = released_q;
	assign modifiers  = modifiers_q;
	assign codepoint  = codepoint_q;

`ifndef SYNTHESIS
	a_unknown_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !recognized |-> codepoint == '0)
		else $error("unknown key produced a character");

	a_ext_only_altgr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && extended && recognized |-> key_code == SC_ALT)
		else $error("prefixed key other than right alt recognized");

	a_prefix_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && is_prefix |-> !out_load)
		else $error("prefix byte produced a request");

	a_bypass_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(byp_s1) |-> $past(consume))
		else $error("state bypass set without a write");
`endif

endmodule
